### hw/rtl/ftel_pkg.sv
`timescale 1ns / 1ps
package ftel_pkg;
  localparam int LogDepth   = 1024;
  localparam int WatchDepth = 64;
  localparam int LogAw      = $clog2(LogDepth);
  localparam int PtrW       = LogAw + 1;
  localparam int WatchAw    = $clog2(WatchDepth);
  localparam int WcntW      = WatchAw + 1;

  typedef enum logic [1:0] {
    REQ_ENTRY = 2'd0,
    REQ_EXIT  = 2'd1,
    REQ_WATCH = 2'd2,
    REQ_POP   = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_LOGGED     = 3'd0,
    ST_FILTERED   = 3'd1,
    ST_DROPPED    = 3'd2,
    ST_WATCH_ADD  = 3'd3,
    ST_WATCH_CLR  = 3'd4,
    ST_WATCH_FULL = 3'd5,
    ST_POPPED     = 3'd6,
    ST_EMPTY      = 3'd7
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_READ,
    S_DONE
  } state_t;

  typedef struct packed {
    logic        kind;
    logic [63:0] addr;
    logic [63:0] tstamp;
    logic [31:0] pid;
    logic [63:0] w1;
    logic [63:0] w2;
    logic [63:0] w3;
    logic [63:0] w4;
  } log_entry_t;
endpackage

### hw/rtl/ftel_log_mem.sv
`timescale 1ns / 1ps
module ftel_log_mem import ftel_pkg::*; (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [LogAw-1:0]  wr_addr,
  input  log_entry_t        wr_data,
  input  logic [LogAw-1:0]  rd_addr,
  output log_entry_t        rd_data
);
  log_entry_t mem [LogDepth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

### hw/rtl/filtered_trace_event_log_top.sv
`timescale 1ns / 1ps
// Path from acceptance to result: a filtered event without a process, a watch clear,
// a refused watch or an empty pop go straight to S_DONE; a pop passes through S_READ;
// a checked event scans the watch entries in S_SCAN until a hit or the last entry;
// an insert shifts larger entries up in S_SHIFT and then writes the new process id.
// One item at a time: in_stall is high from acceptance until the result is transferred.
// Reset (synchronous, rst_n low) clears pointers, counters, watch count and capture_all.
module filtered_trace_event_log_top import ftel_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_capture_all,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic        in_has_process,
  input  logic [30:0] in_proc_id,
  input  logic [63:0] in_code_addr,
  input  logic [63:0] in_timestamp,
  input  logic [63:0] in_arg0,
  input  logic [63:0] in_arg1,
  input  logic [63:0] in_arg2,
  input  logic [63:0] in_arg3,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic        out_event_kind,
  output logic [63:0] out_out_addr,
  output logic [63:0] out_out_time,
  output logic signed [31:0] out_out_pid,
  output logic [63:0] out_out_word1,
  output logic [63:0] out_out_word2,
  output logic [63:0] out_out_word3,
  output logic [63:0] out_out_word4,
  output logic [31:0] out_entry_hit_count,
  output logic [31:0] out_exit_hit_count,
  output logic [10:0] out_fill_level
);
  state_t state_r, state_nxt;
  logic capture_all_r;
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [WcntW-1:0] wcnt_r, widx_r;
  logic [31:0] entry_hits_r, exit_hits_r;
  logic [30:0] watch_tab [WatchDepth];
  logic [30:0] wt_rd_r;

  logic [30:0] pid_r;
  log_entry_t ent_r, rd_data, pop_r;
  status_t status_r;
  logic match_r;

  logic [PtrW-1:0] fill;
  logic accept_in, out_xfer, log_wr;
  logic [WcntW-1:0] wt_rd_idx;
  logic [WatchAw-1:0] wt_rd_addr;
  logic wt_we;
  logic [WatchAw-1:0] wt_wa;
  logic [30:0] wt_wd;
  logic scan_hit, scan_end, sh_move;

  assign accept_in = in_valid && !in_stall;
  assign out_xfer  = out_valid && !out_stall;
  assign fill      = wr_ptr_r - rd_ptr_r;
  assign cfg_ready = (state_r == S_IDLE);
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);
  assign wt_rd_addr = wt_rd_idx[WatchAw-1:0];

  // watch table: one registered read port feeding the scan and shift compares, one write port
  always_ff @(posedge clk) begin
    if (wt_we) watch_tab[wt_wa] <= wt_wd;
    wt_rd_r <= watch_tab[wt_rd_addr];
  end

  ftel_log_mem u_mem (
    .clk(clk), .wr_en(log_wr), .wr_addr(wr_ptr_r[LogAw-1:0]), .wr_data(ent_r),
    .rd_addr(rd_ptr_r[LogAw-1:0]), .rd_data(rd_data)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept_in) begin
        unique case (req_t'(in_req_type))
          REQ_ENTRY, REQ_EXIT:
            state_nxt = (!capture_all_r && !in_has_process) ? S_DONE : S_SCAN;
          REQ_WATCH:
            state_nxt = (in_proc_id == '0 || wcnt_r >= WcntW'(WatchDepth)) ? S_DONE : S_SHIFT;
          REQ_POP: state_nxt = (fill == '0) ? S_DONE : S_READ;
          default: state_nxt = S_DONE;
        endcase
      end
      S_SCAN: if (scan_hit || scan_end) state_nxt = S_DONE;
      S_SHIFT: if (!sh_move) state_nxt = S_DONE;
      S_READ: state_nxt = S_DONE;
      S_DONE: if (out_xfer) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs: wt_rd_r holds the entry at widx_r (scan) or widx_r - 1 (shift)
  always_comb begin
    scan_hit = match_r || (wt_rd_r == pid_r);
    scan_end = (widx_r + WcntW'(1)) >= wcnt_r;
    log_wr   = (state_r == S_SCAN) && scan_hit && (fill < PtrW'(LogDepth));
    sh_move  = (state_r == S_SHIFT) && (widx_r != '0) && (wt_rd_r > pid_r);
    wt_we    = (state_r == S_SHIFT);
    wt_wa    = widx_r[WatchAw-1:0];
    wt_wd    = sh_move ? wt_rd_r : pid_r;
    wt_rd_idx = '0;
    unique case (state_r)
      S_IDLE: if (req_t'(in_req_type) == REQ_WATCH) wt_rd_idx = wcnt_r - WcntW'(1);
      S_SCAN: wt_rd_idx = widx_r + WcntW'(1);
      S_SHIFT: wt_rd_idx = widx_r - WcntW'(2);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      capture_all_r <= 1'b0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      wcnt_r <= '0;
      entry_hits_r <= '0;
      exit_hits_r <= '0;
      widx_r <= '0;
      match_r <= 1'b0;
      status_r <= ST_LOGGED;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) capture_all_r <= cfg_capture_all;
      unique case (state_r)
        S_IDLE: if (accept_in) begin
          match_r <= capture_all_r || (in_has_process && wcnt_r == '0);
          widx_r <= (req_t'(in_req_type) == REQ_WATCH) ? wcnt_r : '0;
          unique case (req_t'(in_req_type))
            REQ_ENTRY: begin
              entry_hits_r <= entry_hits_r + 32'd1;
              if (!capture_all_r && !in_has_process) status_r <= ST_FILTERED;
            end
            REQ_EXIT: begin
              exit_hits_r <= exit_hits_r + 32'd1;
              if (!capture_all_r && !in_has_process) status_r <= ST_FILTERED;
            end
            REQ_WATCH: begin
              if (in_proc_id == '0) begin
                wcnt_r <= '0;
                status_r <= ST_WATCH_CLR;
              end else if (wcnt_r >= WcntW'(WatchDepth)) begin
                status_r <= ST_WATCH_FULL;
              end
            end
            REQ_POP: if (fill == '0) status_r <= ST_EMPTY;
            default: ;
          endcase
        end
        S_SCAN: begin
          if (log_wr) begin
            status_r <= ST_LOGGED;
            wr_ptr_r <= wr_ptr_r + PtrW'(1);
          end else if (scan_hit) begin
            status_r <= ST_DROPPED;
          end else if (scan_end) begin
            status_r <= ST_FILTERED;
          end else begin
            widx_r <= widx_r + WcntW'(1);
          end
        end
        S_SHIFT: begin
          if (sh_move) begin
            widx_r <= widx_r - WcntW'(1);
          end else begin
            wcnt_r <= wcnt_r + WcntW'(1);
            status_r <= ST_WATCH_ADD;
          end
        end
        S_READ: begin
          status_r <= ST_POPPED;
          rd_ptr_r <= rd_ptr_r + PtrW'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept_in) begin
      pid_r <= in_proc_id;
      ent_r.kind <= (in_req_type == REQ_EXIT);
      ent_r.addr <= in_code_addr;
      ent_r.tstamp <= in_timestamp;
      ent_r.pid <= in_has_process ? {1'b0, in_proc_id} : '1;
      ent_r.w1 <= in_arg0;
      ent_r.w2 <= (in_req_type == REQ_EXIT) ? '0 : in_arg1;
      ent_r.w3 <= (in_req_type == REQ_EXIT) ? '0 : in_arg2;
      ent_r.w4 <= (in_req_type == REQ_EXIT) ? '0 : in_arg3;
    end
    if (state_r == S_READ) pop_r <= rd_data;
  end

  logic is_pop;
  assign is_pop = (status_r == ST_POPPED);
  assign out_status = status_r;
  assign out_event_kind = is_pop ? pop_r.kind : 1'b0;
  assign out_out_addr   = is_pop ? pop_r.addr : '0;
  assign out_out_time   = is_pop ? pop_r.tstamp : '0;
  assign out_out_pid    = is_pop ? signed'(pop_r.pid) : '0;
  assign out_out_word1  = is_pop ? pop_r.w1 : '0;
  assign out_out_word2  = is_pop ? pop_r.w2 : '0;
  assign out_out_word3  = is_pop ? pop_r.w3 : '0;
  assign out_out_word4  = is_pop ? pop_r.w4 : '0;
  assign out_entry_hit_count = entry_hits_r;
  assign out_exit_hit_count  = exit_hits_r;
  assign out_fill_level = fill;

  property p_no_overfill;
    @(posedge clk) disable iff (!rst_n) fill <= PtrW'(LogDepth);
  endproperty
  a_no_overfill: assert property (p_no_overfill) else $error("log overfilled");

  property p_wcnt_bound;
    @(posedge clk) disable iff (!rst_n) wcnt_r <= WcntW'(WatchDepth);
  endproperty
  a_wcnt_bound: assert property (p_wcnt_bound) else $error("watch count overflow");

  property p_busy;
    @(posedge clk) disable iff (!rst_n) out_valid |-> in_stall;
  endproperty
  a_busy: assert property (p_busy) else $error("accepting while result pending");

  property p_hold;
    @(posedge clk) disable iff (!rst_n)
      out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_fill_level);
  endproperty
  a_hold: assert property (p_hold) else $error("stalled result changed");
endmodule
